@@ rtl/core/tpw_pkg.sv @@
// ----------------------------------------------------------------------------
// tpw_pkg
// shared types and constants for the tiled pixel walk
// ----------------------------------------------------------------------------
package tpw_pkg;

    // pixel coordinates and walk counters
    localparam int COORD_W = 12;
    // image and tile sizes as written through the config port
    localparam int SIDE_W = 13;
    // product of a tile index and a tile edge, with headroom for one more edge
    localparam int PROD_W = COORD_W + SIDE_W;

    localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(4096);

    localparam logic [SIDE_W-1:0] RST_IMAGE_COLUMNS = SIDE_W'(1024);
    localparam logic [SIDE_W-1:0] RST_IMAGE_ROWS    = SIDE_W'(1024);
    localparam logic [SIDE_W-1:0] RST_TILE_EDGE     = SIDE_W'(16);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_COLUMNS = 2'd0,
        REG_IMAGE_ROWS    = 2'd1,
        REG_TILE_EDGE     = 2'd2
    } tpw_reg_idx_t;

    // effective sizes, already clamped to 1..MAX_SIDE
    typedef struct packed {
        logic [SIDE_W-1:0] image_columns;
        logic [SIDE_W-1:0] image_rows;
        logic [SIDE_W-1:0] tile_edge;
    } tpw_size_t;

    // walk position
    typedef struct packed {
        logic [COORD_W-1:0] row_in_tile;
        logic [COORD_W-1:0] col_in_tile;
        logic [COORD_W-1:0] tile_row_index;
        logic [COORD_W-1:0] tile_col_index;
    } tpw_pos_t;

    // one result item
    typedef struct packed {
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic               frame_end;
    } tpw_result_t;

endpackage

@@ rtl/core/tiled_pixel_walk.sv @@
// ----------------------------------------------------------------------------
// tiled_pixel_walk
// tiled column-order scan address generator: visits every pixel tile by tile
// result: registered, shown in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while out_ready drains the output; the
//   position update (one 12x13 multiply per axis, with adds and compares) is combinational
// reset: walk at the origin, sizes 1024 x 1024 with 16 pixel tiles
// ----------------------------------------------------------------------------
module tiled_pixel_walk (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration writes
    input  logic                              cfg_we,
    input  logic [tpw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpw_pkg::SIDE_W-1:0]        cfg_wdata,

    // tick channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              restart,

    // pixel channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tpw_pkg::COORD_W-1:0]       pixel_row,
    output logic [tpw_pkg::COORD_W-1:0]       pixel_col,
    output logic                              frame_end
);

    tpw_pkg::tpw_size_t    size;
    tpw_pkg::tpw_pos_t     pos_reg;
    tpw_pkg::tpw_pos_t     pos_next;
    tpw_pkg::tpw_result_t  step_result;
    tpw_pkg::tpw_result_t  result_reg;
    logic                  out_valid_reg;
    logic                  in_accept;

    // effective image and tile sizes
    tpw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .size      (size)
    );

    // pixel for this tick and where the walk goes next
    tpw_step u_step (
        .cur     (pos_reg),
        .size    (size),
        .restart (restart),
        .nxt     (pos_next),
        .result  (step_result)
    );

    // a new tick is taken whenever the result register is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // walk position only moves on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (in_accept)
        begin
            pos_reg <= pos_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_row = result_reg.pixel_row;
    assign pixel_col = result_reg.pixel_col;
    assign frame_end = result_reg.frame_end;

    // last pixel of a frame sends the walk back to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && step_result.frame_end) |=> (pos_reg == '0))
        else $error("walk did not wrap after frame end");

    // any other pixel leaves the walk off the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !step_result.frame_end) |=> (pos_reg != '0))
        else $error("walk reached origin without frame end");

    // a restart transaction reports the origin pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && restart) |=> (out_valid && pixel_row == '0 && pixel_col == '0))
        else $error("restart did not report the origin");

endmodule

@@ rtl/core/tpw_cfg.sv @@
// ----------------------------------------------------------------------------
// tpw_cfg
// size registers; values are clamped to 1..MAX_SIDE when written
// ----------------------------------------------------------------------------
module tpw_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpw_pkg::SIDE_W-1:0]         cfg_wdata,
    output tpw_pkg::tpw_size_t                 size
);

    logic [tpw_pkg::SIDE_W-1:0] wdata_eff;
    logic [tpw_pkg::SIDE_W-1:0] cols_reg;
    logic [tpw_pkg::SIDE_W-1:0] rows_reg;
    logic [tpw_pkg::SIDE_W-1:0] edge_reg;

    // zero reads as one, anything past the limit saturates
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            wdata_eff = tpw_pkg::SIDE_W'(1);
        end
        else if (cfg_wdata > tpw_pkg::MAX_SIDE)
        begin
            wdata_eff = tpw_pkg::MAX_SIDE;
        end
        else
        begin
            wdata_eff = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= tpw_pkg::RST_IMAGE_COLUMNS;
            rows_reg <= tpw_pkg::RST_IMAGE_ROWS;
            edge_reg <= tpw_pkg::RST_TILE_EDGE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpw_pkg::REG_IMAGE_COLUMNS: cols_reg <= wdata_eff;
                tpw_pkg::REG_IMAGE_ROWS:    rows_reg <= wdata_eff;
                tpw_pkg::REG_TILE_EDGE:     edge_reg <= wdata_eff;
                default:                    ;
            endcase
        end
    end

    assign size.image_columns = cols_reg;
    assign size.image_rows    = rows_reg;
    assign size.tile_edge     = edge_reg;

endmodule

@@ rtl/core/tpw_step.sv @@
// ----------------------------------------------------------------------------
// tpw_step
// current pixel and next walk position from the present position
// ----------------------------------------------------------------------------
module tpw_step (
    input  tpw_pkg::tpw_pos_t     cur,
    input  tpw_pkg::tpw_size_t    size,
    input  logic                  restart,
    output tpw_pkg::tpw_pos_t     nxt,
    output tpw_pkg::tpw_result_t  result
);

    localparam int PW = tpw_pkg::PROD_W;

    tpw_pkg::tpw_pos_t  pos;
    logic [PW-1:0]      row_base;
    logic [PW-1:0]      col_base;
    logic [PW-1:0]      edge_w;
    logic [PW-1:0]      rit_inc;
    logic [PW-1:0]      cit_inc;
    logic               row_more;
    logic               col_more;
    logic               tile_row_more;
    logic               tile_col_more;

    // restart puts the walk at the origin before the pixel is reported
    assign pos = restart ? '0 : cur;

    assign edge_w  = PW'(size.tile_edge);
    assign rit_inc = PW'(pos.row_in_tile) + PW'(1);
    assign cit_inc = PW'(pos.col_in_tile) + PW'(1);

    assign row_base = PW'(pos.tile_row_index) * edge_w;
    assign col_base = PW'(pos.tile_col_index) * edge_w;

    // stay inside the tile and inside the image
    assign row_more = (rit_inc < edge_w) &&
                      ((row_base + rit_inc) < PW'(size.image_rows));
    assign col_more = (cit_inc < edge_w) &&
                      ((col_base + cit_inc) < PW'(size.image_columns));
    // next tile index is below ceil(side / edge) exactly when its start lies inside
    assign tile_row_more = (row_base + edge_w) < PW'(size.image_rows);
    assign tile_col_more = (col_base + edge_w) < PW'(size.image_columns);

    always_comb
    begin
        nxt = pos;
        if (row_more)
        begin
            nxt.row_in_tile = rit_inc[tpw_pkg::COORD_W-1:0];
        end
        else
        begin
            nxt.row_in_tile = '0;
            if (col_more)
            begin
                nxt.col_in_tile = cit_inc[tpw_pkg::COORD_W-1:0];
            end
            else
            begin
                nxt.col_in_tile = '0;
                if (tile_row_more)
                begin
                    nxt.tile_row_index = pos.tile_row_index + tpw_pkg::COORD_W'(1);
                end
                else
                begin
                    nxt.tile_row_index = '0;
                    if (tile_col_more)
                    begin
                        nxt.tile_col_index = pos.tile_col_index + tpw_pkg::COORD_W'(1);
                    end
                    else
                    begin
                        nxt.tile_col_index = '0;
                    end
                end
            end
        end
    end

    assign result.pixel_row = row_base[tpw_pkg::COORD_W-1:0] + pos.row_in_tile;
    assign result.pixel_col = col_base[tpw_pkg::COORD_W-1:0] + pos.col_in_tile;
    // every other branch leaves some counter nonzero
    assign result.frame_end = !row_more && !col_more && !tile_row_more && !tile_col_more;

endmodule
